>>> design/pen_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pen_pkg
// shared types and constants of the prewitt edge unit with peak suppression
// ----------------------------------------------------------------------------
package pen_pkg;

    localparam int PIX_W      = 8;
    localparam int EDGE_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int GRAD_W     = 11;
    localparam int SQ_W       = 20;
    localparam int MAG_W      = 21;
    localparam int ROOT_W     = 29;
    localparam int TAP_W      = 4;
    localparam int STEP_W     = 4;
    localparam int DIV3_SHIFT = 17;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0]   FW_RESET   = 11'd640;
    localparam logic [FH_W-1:0]   FH_RESET   = 13'd480;
    localparam logic [TAP_W-1:0]  TAP_LAST   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_LAST  = 4'd14;
    localparam logic [15:0]       DIV3_RECIP = 16'hAAAB;
    localparam logic [ROOT_W-1:0] ROOT_BIT0  = 29'h1000_0000;

    localparam logic [1:0] SEL_CENTER = 2'd0;
    localparam logic [1:0] SEL_N1     = 2'd1;
    localparam logic [1:0] SEL_N2     = 2'd2;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] pixel;
    } px_item_t;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        logic              frame_last;
    } res_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_GRAD,
        ST_GWRITE,
        ST_MRD,
        ST_MLAT,
        ST_MSQX,
        ST_MSQY,
        ST_KEEP,
        ST_SQRT,
        ST_DIV,
        ST_FIN
    } pen_state_t;

    typedef struct packed {
        logic             item_load;
        logic             cfg_write;
        logic             decide;
        logic             grad_run;
        logic [TAP_W-1:0] tap;
        logic             grad_write;
        logic             mag_rd;
        logic             mag_lat;
        logic             mag_sqx;
        logic             mag_sqy;
        logic [1:0]       sel;
        logic             sq_init;
        logic             sq_step;
        logic             div3;
        logic             out_load;
        logic             commit;
    } pen_cmd_t;

    typedef struct packed {
        logic drop;
        logic need_grad;
        logic need_out;
        logic border;
        logic keep;
        logic out_space;
    } pen_stat_t;

endpackage
`default_nettype wire

>>> design/pen_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pen_ctrl
// sequencer stepping each item through gradient, magnitude, root and output
// ----------------------------------------------------------------------------
module pen_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              px_valid,
    output logic                   px_ready,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire pen_pkg::pen_stat_t stat,
    output pen_pkg::pen_cmd_t      cmd
);

    pen_pkg::pen_state_t            state_reg, state_next;
    logic [pen_pkg::TAP_W-1:0]      tap_reg, tap_next;
    logic [1:0]                     sel_reg, sel_next;
    logic [pen_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                           fin_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pen_pkg::ST_IDLE;
            tap_reg   <= '0;
            sel_reg   <= pen_pkg::SEL_CENTER;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            sel_reg   <= sel_next;
            step_reg  <= step_next;
        end
    end

    assign fin_go = (state_reg == pen_pkg::ST_FIN) && (!stat.need_out || stat.out_space);

    always_comb
    begin
        state_next = state_reg;
        tap_next   = '0;
        sel_next   = sel_reg;
        step_next  = '0;
        unique case (state_reg)
            pen_pkg::ST_IDLE:
            begin
                if (px_valid)
                    state_next = pen_pkg::ST_DECIDE;
            end
            pen_pkg::ST_DECIDE:
            begin
                sel_next = pen_pkg::SEL_CENTER;
                priority if (stat.drop)
                    state_next = pen_pkg::ST_IDLE;
                else if (stat.need_grad)
                    state_next = pen_pkg::ST_GRAD;
                else if (stat.need_out && !stat.border)
                    state_next = pen_pkg::ST_MRD;
                else
                    state_next = pen_pkg::ST_FIN;
            end
            pen_pkg::ST_GRAD:
            begin
                tap_next = tap_reg + 1'b1;
                if (tap_reg == pen_pkg::TAP_LAST)
                    state_next = pen_pkg::ST_GWRITE;
            end
            pen_pkg::ST_GWRITE:
            begin
                if (stat.need_out && !stat.border)
                    state_next = pen_pkg::ST_MRD;
                else
                    state_next = pen_pkg::ST_FIN;
            end
            pen_pkg::ST_MRD:  state_next = pen_pkg::ST_MLAT;
            pen_pkg::ST_MLAT: state_next = pen_pkg::ST_MSQX;
            pen_pkg::ST_MSQX: state_next = pen_pkg::ST_MSQY;
            pen_pkg::ST_MSQY:
            begin
                if (sel_reg == pen_pkg::SEL_N2)
                    state_next = pen_pkg::ST_KEEP;
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = pen_pkg::ST_MRD;
                end
            end
            pen_pkg::ST_KEEP:
            begin
                state_next = stat.keep ? pen_pkg::ST_SQRT : pen_pkg::ST_FIN;
            end
            pen_pkg::ST_SQRT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == pen_pkg::STEP_LAST)
                    state_next = pen_pkg::ST_DIV;
            end
            pen_pkg::ST_DIV: state_next = pen_pkg::ST_FIN;
            pen_pkg::ST_FIN:
            begin
                if (fin_go)
                    state_next = pen_pkg::ST_IDLE;
            end
            default: state_next = pen_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        px_ready       = (state_reg == pen_pkg::ST_IDLE);
        cfg_ready      = (state_reg == pen_pkg::ST_IDLE) && !px_valid;
        cmd            = '0;
        cmd.item_load  = px_ready && px_valid;
        cmd.cfg_write  = cfg_ready && cfg_valid;
        cmd.decide     = (state_reg == pen_pkg::ST_DECIDE) && !stat.drop;
        cmd.grad_run   = (state_reg == pen_pkg::ST_GRAD);
        cmd.tap        = tap_reg;
        cmd.grad_write = (state_reg == pen_pkg::ST_GWRITE);
        cmd.mag_rd     = (state_reg == pen_pkg::ST_MRD);
        cmd.mag_lat    = (state_reg == pen_pkg::ST_MLAT);
        cmd.mag_sqx    = (state_reg == pen_pkg::ST_MSQX);
        cmd.mag_sqy    = (state_reg == pen_pkg::ST_MSQY);
        cmd.sel        = sel_reg;
        cmd.sq_init    = (state_reg == pen_pkg::ST_KEEP) && stat.keep;
        cmd.sq_step    = (state_reg == pen_pkg::ST_SQRT);
        cmd.div3       = (state_reg == pen_pkg::ST_DIV);
        cmd.out_load   = fin_go && stat.need_out;
        cmd.commit     = fin_go;
    end

endmodule
`default_nettype wire

>>> design/pen_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pen_dpath
// line memories, position counters, gradient sums, magnitudes, root and output
// ----------------------------------------------------------------------------
module pen_dpath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire pen_pkg::pen_cmd_t                  cmd,
    output pen_pkg::pen_stat_t                      stat,
    input  wire pen_pkg::px_item_t                  px_item,
    input  wire logic [pen_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pen_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output pen_pkg::res_item_t                      res_item
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CIW = $clog2(MAX_WIDTH);
    localparam int RIW = $clog2(MAX_HEIGHT);
    localparam int PW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);
    localparam int PAW = $clog2(4 * MAX_WIDTH);
    localparam int GAW = $clog2(3 * MAX_WIDTH);
    localparam int GW  = pen_pkg::GRAD_W;

    logic [pen_pkg::FW_W-1:0]  fw_reg;
    logic [pen_pkg::FH_W-1:0]  fh_reg;
    logic [WW-1:0]             weff;
    logic [HW-1:0]             heff;
    logic [PW-1:0]             total_reg;
    logic                      icmd_reg;
    logic [pen_pkg::PIX_W-1:0] ipix_reg;

    logic [PW-1:0]  p_reg;
    logic [CIW-1:0] in_col_reg;
    logic [1:0]     in_m4_reg;
    logic [RIW-1:0] gr_reg;
    logic [CIW-1:0] gc_reg;
    logic [1:0]     g_m3_reg;
    logic [RIW-1:0] or_reg;
    logic [CIW-1:0] oc_reg;
    logic [1:0]     o_m3_reg;

    logic [pen_pkg::PIX_W-1:0] pmem [4 * MAX_WIDTH];
    logic [pen_pkg::PIX_W-1:0] pmem_q;
    logic [2*GW-1:0]           gmem [3 * MAX_WIDTH];
    logic [2*GW-1:0]           gmem_q;

    logic signed [GW-1:0] sx_acc, sy_acc, cen_sx, cen_sy, cur_sx, cur_sy;
    logic [pen_pkg::SQ_W-1:0]    sqx_reg;
    logic [pen_pkg::MAG_W-1:0]   mag_c, mag_1, mag_2, mag_sum;
    logic [pen_pkg::ROOT_W-1:0]  v_reg, root_reg, bit_reg;
    logic [pen_pkg::ROOT_W:0]    trial;
    logic [pen_pkg::EDGE_W-1:0]  val_reg;
    logic [30:0]                 div_prod;
    logic signed [2*GW-1:0]      sq_x, sq_y;

    logic [31:0] w32, h32, p32, t32;
    logic        pix_in, last;
    logic [31:0] a32, b32, l32, rt32, prow, pcol;
    logic [PAW-1:0] prd_addr, pwr_addr;
    logic [GAW-1:0] grd_addr, gwr_addr;
    logic [3:0]  tap_d;
    logic signed [GW-1:0] pval;
    logic signed [1:0] dr, dc;
    logic [1:0]  grow;
    logic [31:0] gcol;

    // effective frame size
    always_comb
    begin
        w32 = 32'(fw_reg);
        h32 = 32'(fh_reg);
        if (w32 < 32'd4)
            w32 = 32'd4;
        else if (w32 > 32'(MAX_WIDTH))
            w32 = 32'(MAX_WIDTH);
        if (h32 < 32'd4)
            h32 = 32'd4;
        else if (h32 > 32'(MAX_HEIGHT))
            h32 = 32'(MAX_HEIGHT);
        weff = WW'(w32);
        heff = HW'(h32);
    end

    assign p32 = 32'(p_reg);
    assign t32 = 32'(total_reg);

    assign pix_in = p32 < t32;
    assign last   = (32'(or_reg) + 32'd1 >= 32'(heff)) && (32'(oc_reg) + 32'd1 >= 32'(weff));
    assign mag_sum = {1'b0, sqx_reg} + {1'b0, sq_y[pen_pkg::SQ_W-1:0]};

    always_comb
    begin
        stat.drop      = pix_in && icmd_reg;
        stat.need_grad = (p32 >= 32'(weff) + 32'd1) && (p32 < t32 + 32'(weff) + 32'd1);
        stat.need_out  = p32 >= 32'd2 * 32'(weff) + 32'd2;
        stat.border    = (or_reg == '0) || (oc_reg == '0) ||
                         (32'(or_reg) + 32'd1 >= 32'(heff)) ||
                         (32'(oc_reg) + 32'd1 >= 32'(weff));
        stat.keep      = (mag_c > mag_1) && (mag_c > mag_2);
        stat.out_space = !res_valid || res_ready;
    end

    // configuration, item latch and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg     <= pen_pkg::FW_RESET;
            fh_reg     <= pen_pkg::FH_RESET;
            total_reg  <= '0;
            p_reg      <= '0;
            in_col_reg <= '0;
            in_m4_reg  <= '0;
            gr_reg     <= '0;
            gc_reg     <= '0;
            g_m3_reg   <= '0;
            or_reg     <= '0;
            oc_reg     <= '0;
            o_m3_reg   <= '0;
        end
        else
        begin
            total_reg <= PW'(32'(weff) * 32'(heff));
            if (cmd.cfg_write &&
                (cfg_index == pen_pkg::REG_FRAME_WIDTH || cfg_index == pen_pkg::REG_FRAME_HEIGHT))
            begin
                if (cfg_index == pen_pkg::REG_FRAME_WIDTH)
                    fw_reg <= cfg_data[pen_pkg::FW_W-1:0];
                else
                    fh_reg <= cfg_data[pen_pkg::FH_W-1:0];
                p_reg <= '0; in_col_reg <= '0; in_m4_reg <= '0;
                gr_reg <= '0; gc_reg <= '0; g_m3_reg <= '0;
                or_reg <= '0; oc_reg <= '0; o_m3_reg <= '0;
            end
            if (cmd.grad_write)
            begin
                if (32'(gc_reg) + 32'd1 >= 32'(weff))
                begin
                    gc_reg   <= '0;
                    gr_reg   <= gr_reg + 1'b1;
                    g_m3_reg <= (g_m3_reg == 2'd2) ? 2'd0 : g_m3_reg + 2'd1;
                end
                else
                    gc_reg <= gc_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                if (stat.need_out && last)
                begin
                    p_reg <= '0; in_col_reg <= '0; in_m4_reg <= '0;
                    gr_reg <= '0; gc_reg <= '0; g_m3_reg <= '0;
                    or_reg <= '0; oc_reg <= '0; o_m3_reg <= '0;
                end
                else
                begin
                    if (stat.need_out)
                    begin
                        if (32'(oc_reg) + 32'd1 >= 32'(weff))
                        begin
                            oc_reg   <= '0;
                            or_reg   <= or_reg + 1'b1;
                            o_m3_reg <= (o_m3_reg == 2'd2) ? 2'd0 : o_m3_reg + 2'd1;
                        end
                        else
                            oc_reg <= oc_reg + 1'b1;
                    end
                    p_reg <= p_reg + 1'b1;
                    if (32'(in_col_reg) + 32'd1 >= 32'(weff))
                    begin
                        in_col_reg <= '0;
                        in_m4_reg  <= in_m4_reg + 2'd1;
                    end
                    else
                        in_col_reg <= in_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            icmd_reg <= px_item.cmd;
            ipix_reg <= px_item.pixel;
        end
    end

    // pixel window taps with mirrored borders
    always_comb
    begin
        a32  = (gr_reg == '0) ? 32'd1 : 32'(gr_reg) - 32'd1;
        b32  = (32'(gr_reg) + 32'd1 >= 32'(heff)) ? 32'(heff) - 32'd2 : 32'(gr_reg) + 32'd1;
        l32  = (gc_reg == '0) ? 32'd1 : 32'(gc_reg) - 32'd1;
        rt32 = (32'(gc_reg) + 32'd1 >= 32'(weff)) ? 32'(weff) - 32'd2 : 32'(gc_reg) + 32'd1;
        unique case (cmd.tap)
            4'd0:    begin prow = a32;            pcol = l32;            end
            4'd1:    begin prow = a32;            pcol = 32'(gc_reg);    end
            4'd2:    begin prow = a32;            pcol = rt32;           end
            4'd3:    begin prow = b32;            pcol = l32;            end
            4'd4:    begin prow = b32;            pcol = 32'(gc_reg);    end
            4'd5:    begin prow = b32;            pcol = rt32;           end
            4'd6:    begin prow = 32'(gr_reg);    pcol = l32;            end
            4'd7:    begin prow = 32'(gr_reg);    pcol = rt32;           end
            default: begin prow = 32'(gr_reg);    pcol = 32'(gc_reg);    end
        endcase
        prd_addr = PAW'({30'd0, prow[1:0]} * 32'(MAX_WIDTH) + pcol);
        pwr_addr = PAW'({30'd0, in_m4_reg} * 32'(MAX_WIDTH) + 32'(in_col_reg));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide && pix_in)
            pmem[pwr_addr] <= ipix_reg;
        pmem_q <= pmem[prd_addr];
    end

    assign tap_d = cmd.tap - 4'd1;
    assign pval  = $signed({3'b000, pmem_q});

    always_ff @(posedge clk)
    begin
        if (cmd.grad_run)
        begin
            if (cmd.tap == '0)
            begin
                sx_acc <= '0;
                sy_acc <= '0;
            end
            else
            begin
                if (tap_d <= 4'd2)
                    sx_acc <= sx_acc + pval;
                else if (tap_d <= 4'd5)
                    sx_acc <= sx_acc - pval;
                if (tap_d == 4'd0 || tap_d == 4'd3 || tap_d == 4'd6)
                    sy_acc <= sy_acc + pval;
                else if (tap_d == 4'd2 || tap_d == 4'd5 || tap_d == 4'd7)
                    sy_acc <= sy_acc - pval;
            end
        end
    end

    // gradient lines and neighbour selection by sector
    always_comb
    begin
        if (cen_sy == '0)
        begin
            dr = 2'sd0;  dc = 2'sd1;
        end
        else if (cen_sx == '0)
        begin
            dr = 2'sd1;  dc = 2'sd0;
        end
        else if ((cen_sx > 0) == (cen_sy > 0))
        begin
            dr = 2'sd1;  dc = 2'sd1;
        end
        else
        begin
            dr = 2'sd1;  dc = -2'sd1;
        end
        if (cmd.sel == pen_pkg::SEL_CENTER)
        begin
            dr = 2'sd0;  dc = 2'sd0;
        end
        else if (cmd.sel == pen_pkg::SEL_N2)
        begin
            dr = -dr;    dc = -dc;
        end
        if (dr == 2'sd1)
            grow = (o_m3_reg == 2'd2) ? 2'd0 : o_m3_reg + 2'd1;
        else if (dr == -2'sd1)
            grow = (o_m3_reg == 2'd0) ? 2'd2 : o_m3_reg - 2'd1;
        else
            grow = o_m3_reg;
        gcol     = 32'(oc_reg) + 32'($signed(dc));
        grd_addr = GAW'({30'd0, grow} * 32'(MAX_WIDTH) + gcol);
        gwr_addr = GAW'({30'd0, g_m3_reg} * 32'(MAX_WIDTH) + 32'(gc_reg));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.grad_write)
            gmem[gwr_addr] <= {sx_acc, sy_acc};
        gmem_q <= gmem[grd_addr];
    end

    assign sq_x = cur_sx * cur_sx;
    assign sq_y = cur_sy * cur_sy;
    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign div_prod = root_reg[14:0] * pen_pkg::DIV3_RECIP;

    // squared magnitudes, bitwise root and scaling by a third
    always_ff @(posedge clk)
    begin
        if (cmd.mag_lat)
        begin
            cur_sx <= gmem_q[2*GW-1:GW];
            cur_sy <= gmem_q[GW-1:0];
            if (cmd.sel == pen_pkg::SEL_CENTER)
            begin
                cen_sx <= gmem_q[2*GW-1:GW];
                cen_sy <= gmem_q[GW-1:0];
            end
        end
        if (cmd.mag_sqx)
            sqx_reg <= sq_x[pen_pkg::SQ_W-1:0];
        if (cmd.mag_sqy)
        begin
            unique case (cmd.sel)
                pen_pkg::SEL_CENTER: mag_c <= mag_sum;
                pen_pkg::SEL_N1:     mag_1 <= mag_sum;
                default:             mag_2 <= mag_sum;
            endcase
        end
        if (cmd.sq_init)
        begin
            v_reg    <= {mag_c, 8'd0};
            root_reg <= '0;
            bit_reg  <= pen_pkg::ROOT_BIT0;
        end
        else if (cmd.sq_step)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_reg    <= v_reg - trial[pen_pkg::ROOT_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.decide)
            val_reg <= '0;
        else if (cmd.div3)
            val_reg <= div_prod[pen_pkg::DIV3_SHIFT +: pen_pkg::EDGE_W];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid <= 1'b0;
        else if (cmd.out_load)
            res_valid <= 1'b1;
        else if (res_ready)
            res_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_item.edge_value <= val_reg;
            res_item.frame_last <= last;
        end
    end

    a_load_space: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!res_valid || res_ready))
        else $error("result overwritten while held");

    a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sq_step |-> $onehot(bit_reg))
        else $error("root trial bit lost");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && stat.need_out && last && !cmd.cfg_write) |=> (p_reg == '0))
        else $error("frame did not restart after last result");

endmodule
`default_nettype wire

>>> design/prewitt_edge_nms_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prewitt_edge_nms_unit
// prewitt gradient magnitude of a raster pixel stream with peak suppression
// ----------------------------------------------------------------------------
// px channel takes one item at a time: cmd 0 is a pixel, cmd 1 a flush tick.
// after the last pixel of a frame, 2*width+2 further items drain the results.
// res channel gives one result per item once 2*width+2 items of the frame
// have gone in, with frame_last on the final pixel of the frame.
// cfg channel writes frame_width (index 0) or frame_height (index 1) and
// restarts the frame; it is taken only while no item is in progress.
// an item that needs a gradient makes 9 pixel line reads; the longest item
// also forms three squared magnitudes, squaring the x and y parts in turn,
// and for a kept peak runs 15 root iterations and the scaling step.
// the result sits in an output register, so the next item is taken while a
// result waits; a stalled receiver holds the block only when a new result
// is ready to replace the one still waiting.
// reset restores 640 x 480 and position zero; line memories are not cleared.
// ----------------------------------------------------------------------------
module prewitt_edge_nms_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           px_valid,
    output logic                                px_ready,
    input  wire pen_pkg::px_item_t              px_item,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output pen_pkg::res_item_t                  res_item,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pen_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pen_pkg::CFG_DATA_W-1:0] cfg_data
);

    pen_pkg::pen_cmd_t  cmd;
    pen_pkg::pen_stat_t stat;

    pen_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .px_valid  (px_valid),
        .px_ready  (px_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pen_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .px_item   (px_item),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule
`default_nettype wire
